### rtl/core/assert_macros.svh
// Assertion macros shared by the sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### rtl/core/pabs_pkg.sv
// Types, codes and constants of the phased-array burst sequencer.
`timescale 1ns / 1ps
package pabs_pkg;

  // Request operation codes
  typedef enum logic [2:0] {
    OP_START_US  = 3'd0,
    OP_START_IR  = 3'd1,
    OP_CPU_CYCLE = 3'd2,
    OP_PWM_EVENT = 3'd3,
    OP_TIMER     = 3'd4
  } op_t;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_BURST_COUNT     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RECEIVER_ON     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GROUND_OFF      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_FINISH          = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_INFRARED_LENGTH = 3'd4;
  localparam int CFG_DATA_W = 8;

  // Register reset values
  localparam logic [6:0] BURST_COUNT_RST     = 7'd10;
  localparam logic [7:0] RECEIVER_ON_RST     = 8'd60;
  localparam logic [7:0] GROUND_OFF_RST      = 8'd70;
  localparam logic [7:0] FINISH_RST          = 8'd80;
  localparam logic [7:0] INFRARED_LENGTH_RST = 8'd40;

  // Stagger delay in cpu cycles per steering angle magnitude
  localparam int STAGGER_W = 10;
  localparam logic [4:0] STAGGER_MIN = 5'd3;
  localparam logic [4:0] STAGGER_MAX = 5'd30;
  localparam logic [STAGGER_W-1:0] STAGGER_TABLE [0:30] = '{
    10'd0,   10'd0,   10'd0,   10'd19,  10'd38,  10'd57,  10'd76,  10'd94,
    10'd113, 10'd132, 10'd151, 10'd170, 10'd189, 10'd211, 10'd230, 10'd249,
    10'd268, 10'd287, 10'd305, 10'd324, 10'd344, 10'd362, 10'd385, 10'd403,
    10'd420, 10'd439, 10'd458, 10'd476, 10'd494, 10'd515, 10'd538
  };

  localparam logic [7:0] TICK_MAX = 8'd255;

  // Request payload
  typedef struct packed {
    logic [2:0]        operation;
    logic signed [7:0] steer_angle;
    logic [7:0]        period_mask;
  } cmd_t;

  // Result payload
  typedef struct packed {
    logic [7:0] channel_enables;
    logic       transmit_enable;
    logic       ground_switch_closed;
    logic       receiver_enable;
    logic       infrared_out;
    logic       busy_res;
    logic       finished;
  } rsp_t;

  // Control from the sequencer to the channel bank
  typedef struct packed {
    logic enable;  // enable the indexed channel
    logic count;   // count period events
  } chan_ctrl_t;

endpackage

### rtl/core/pabs_chan_bank.sv
// Channel bank: per-channel enables and PWM period burst counters.
`timescale 1ns / 1ps
module pabs_chan_bank import pabs_pkg::*; #(
  parameter int CHANNEL_COUNT = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  chan_ctrl_t                       ctrl,
  input  logic [$clog2(CHANNEL_COUNT)-1:0] enable_index,
  input  logic [7:0]                       period_mask,
  input  logic [6:0]                       burst_count,
  output logic [CHANNEL_COUNT-1:0]         enabled_next,
  output logic [CHANNEL_COUNT-1:0]         stopped
);

  localparam int PadW = (CHANNEL_COUNT > 8) ? CHANNEL_COUNT : 8;

  logic [CHANNEL_COUNT-1:0] enabled;
  logic [6:0]               counters      [CHANNEL_COUNT];
  logic [6:0]               counters_next [CHANNEL_COUNT];
  logic [PadW-1:0]          mask_pad;
  logic [CHANNEL_COUNT-1:0] set_bit;

  // Mask bits at or above eight never reach a channel
  assign mask_pad = PadW'(period_mask);
  assign set_bit  = ctrl.enable ? (CHANNEL_COUNT'(1) << enable_index) : '0;

  // Count events on running channels, stop at the burst length
  always_comb begin
    for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
      counters_next[ch] = counters[ch];
      stopped[ch]       = 1'b0;
      if (ctrl.count && mask_pad[ch] && enabled[ch]) begin
        if (7'(counters[ch] + 7'd1) >= burst_count) begin
          counters_next[ch] = '0;
          stopped[ch]       = 1'b1;
        end else begin
          counters_next[ch] = 7'(counters[ch] + 7'd1);
        end
      end
    end
    enabled_next = (enabled & ~stopped) | set_bit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= '0;
      for (int ch = 0; ch < CHANNEL_COUNT; ch++) counters[ch] <= '0;
    end else begin
      enabled <= enabled_next;
      for (int ch = 0; ch < CHANNEL_COUNT; ch++) counters[ch] <= counters_next[ch];
    end
  end

endmodule

### rtl/core/phased_array_burst_sequencer.sv
// Top level of the phased-array burst sequencer: phase control, timers, result register.
// The result of an accepted request is registered and is valid in the cycle after it is accepted.
// Throughput: one request per cycle; a new request is taken at the edge where the waiting
// result leaves, and cmd_stall rises only when the result register is full and rsp_stall is high.
// The whole update for one request is combinational logic ahead of the result register.
// Reset (synchronous): phase idle, all channels and outputs off, counters cleared,
// configuration registers back to their defaults; no clearing pass is needed.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module phased_array_burst_sequencer import pabs_pkg::*; #(
  parameter int CHANNEL_COUNT = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   cmd_valid,
  output logic                   cmd_stall,
  input  cmd_t                   cmd,
  output logic                   rsp_valid,
  input  logic                   rsp_stall,
  output rsp_t                   rsp
);

  localparam int IdxW  = $clog2(CHANNEL_COUNT);
  localparam int LeftW = $clog2(CHANNEL_COUNT + 1);
  localparam int PadW  = (CHANNEL_COUNT > 8) ? CHANNEL_COUNT : 8;
  localparam logic [IdxW-1:0]  LastIdx = IdxW'(CHANNEL_COUNT - 1);
  localparam logic [LeftW-1:0] AllLeft = LeftW'(CHANNEL_COUNT);

  typedef enum logic [2:0] {
    PH_IDLE, PH_STAGGER, PH_SEND, PH_ATTENUATE, PH_INFRARED
  } phase_t;

  // Configuration registers
  logic [6:0] burst_count;
  logic [7:0] receiver_on_base, ground_off_base, finish_base, infrared_length;

  // Sequencer state
  phase_t               phase, phase_next;
  logic                 reverse_order, reverse_order_next;
  logic [IdxW-1:0]      next_channel, next_channel_next;
  logic [LeftW-1:0]     channels_left, channels_left_next;
  logic [STAGGER_W-1:0] stagger_reload, stagger_reload_next;
  logic [STAGGER_W-1:0] stagger_count, stagger_count_next;
  logic [IdxW-1:0]      final_channel, final_channel_next;
  logic [7:0]           tick_count, tick_count_next;
  logic                 driver_on, driver_on_next;
  logic                 ground_on, ground_on_next;
  logic                 receiver_on, receiver_on_next;
  logic                 infrared_on, infrared_on_next;
  logic                 done;

  // Working signals
  logic                     accept;
  op_t                      op;
  logic [7:0]               magnitude;
  logic [IdxW-1:0]          enable_index;
  logic [IdxW-1:0]          stepped_index;
  logic                     do_enable;
  logic [STAGGER_W-1:0]     stagger_dec;
  logic [7:0]               tick_inc;
  logic [8:0]               tick_plus_half;
  chan_ctrl_t               chan_ctrl;
  logic [CHANNEL_COUNT-1:0] enabled_next;
  logic [CHANNEL_COUNT-1:0] stopped;
  logic [PadW-1:0]          enabled_pad;

  assign accept    = cmd_valid && !cmd_stall;
  assign cmd_stall = rsp_valid && rsp_stall;
  assign op        = op_t'(cmd.operation);
  assign magnitude = cmd.steer_angle[7] ? 8'(-cmd.steer_angle) : 8'(cmd.steer_angle);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      burst_count      <= BURST_COUNT_RST;
      receiver_on_base <= RECEIVER_ON_RST;
      ground_off_base  <= GROUND_OFF_RST;
      finish_base      <= FINISH_RST;
      infrared_length  <= INFRARED_LENGTH_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BURST_COUNT:     burst_count      <= cfg_data[6:0];
        REG_RECEIVER_ON:     receiver_on_base <= cfg_data;
        REG_GROUND_OFF:      ground_off_base  <= cfg_data;
        REG_FINISH:          finish_base      <= cfg_data;
        REG_INFRARED_LENGTH: infrared_length  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Channel to enable: the first one on a start, else the stored next one
  always_comb begin
    enable_index = next_channel;
    if (op == OP_START_US) enable_index = cmd.steer_angle[7] ? LastIdx : '0;
    if (reverse_order_next) begin
      stepped_index = (enable_index == '0) ? LastIdx : IdxW'(enable_index - 1'b1);
    end else begin
      stepped_index = (enable_index == LastIdx) ? '0 : IdxW'(enable_index + 1'b1);
    end
  end

  assign stagger_dec    = (stagger_count != '0) ? STAGGER_W'(stagger_count - 1'b1) : '0;
  assign tick_inc       = (tick_count == TICK_MAX) ? TICK_MAX : 8'(tick_count + 8'd1);
  assign tick_plus_half = {1'b0, tick_inc} + {3'b000, burst_count[6:1]};

  // Next state for the accepted request
  always_comb begin
    phase_next          = phase;
    reverse_order_next  = reverse_order;
    next_channel_next   = next_channel;
    channels_left_next  = channels_left;
    stagger_reload_next = stagger_reload;
    stagger_count_next  = stagger_count;
    final_channel_next  = final_channel;
    tick_count_next     = tick_count;
    driver_on_next      = driver_on;
    ground_on_next      = ground_on;
    receiver_on_next    = receiver_on;
    infrared_on_next    = infrared_on;
    done                = 1'b0;
    do_enable           = 1'b0;
    chan_ctrl           = '0;

    if (accept) begin
      case (op)
        OP_START_US: begin
          if (phase == PH_IDLE) begin
            receiver_on_next   = 1'b0;
            driver_on_next     = 1'b1;
            reverse_order_next = cmd.steer_angle[7];
            stagger_reload_next = (magnitude >= 8'(STAGGER_MIN) &&
                                   magnitude <= 8'(STAGGER_MAX)) ?
                                  STAGGER_TABLE[magnitude[4:0]] : '0;
            final_channel_next = cmd.steer_angle[7] ? '0 : LastIdx;
            channels_left_next = AllLeft;
            do_enable          = 1'b1;
          end
        end
        OP_START_IR: begin
          if (phase == PH_IDLE) begin
            infrared_on_next = 1'b1;
            tick_count_next  = '0;
            phase_next       = PH_INFRARED;
          end
        end
        OP_CPU_CYCLE: begin
          if (phase == PH_STAGGER) begin
            stagger_count_next = stagger_dec;
            if (stagger_dec == '0) do_enable = 1'b1;
          end
        end
        OP_PWM_EVENT: begin
          chan_ctrl.count = 1'b1;
          if (stopped[final_channel] && phase == PH_SEND) begin
            driver_on_next  = 1'b0;
            ground_on_next  = 1'b1;
            tick_count_next = '0;
            phase_next      = PH_ATTENUATE;
          end
        end
        OP_TIMER: begin
          if (phase == PH_ATTENUATE) begin
            tick_count_next = tick_inc;
            if (tick_plus_half > {1'b0, receiver_on_base}) receiver_on_next = 1'b1;
            if (tick_plus_half > {1'b0, ground_off_base})  ground_on_next   = 1'b0;
            if (tick_plus_half > {1'b0, finish_base}) begin
              tick_count_next = '0;
              phase_next      = PH_IDLE;
              done            = 1'b1;
            end
          end else if (phase == PH_INFRARED) begin
            tick_count_next = tick_inc;
            if (tick_inc > infrared_length) begin
              infrared_on_next = 1'b0;
              tick_count_next  = '0;
              phase_next       = PH_IDLE;
              done             = 1'b1;
            end
          end
        end
        default: ;
      endcase

      // Enable one channel and advance the stagger sequence
      if (do_enable) begin
        chan_ctrl.enable   = 1'b1;
        next_channel_next  = stepped_index;
        stagger_count_next = stagger_reload_next;
        channels_left_next = (channels_left_next != '0) ?
                             LeftW'(channels_left_next - 1'b1) : '0;
        phase_next = (channels_left_next == '0) ? PH_SEND : PH_STAGGER;
      end
    end
  end

  pabs_chan_bank #(
    .CHANNEL_COUNT(CHANNEL_COUNT)
  ) u_chan_bank (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (chan_ctrl),
    .enable_index (enable_index),
    .period_mask  (cmd.period_mask),
    .burst_count  (burst_count),
    .enabled_next (enabled_next),
    .stopped      (stopped)
  );

  assign enabled_pad = PadW'(enabled_next);

  // Hold state and the result register; load the payload on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      reverse_order  <= 1'b0;
      next_channel   <= '0;
      channels_left  <= '0;
      stagger_reload <= '0;
      stagger_count  <= '0;
      final_channel  <= '0;
      tick_count     <= '0;
      driver_on      <= 1'b0;
      ground_on      <= 1'b0;
      receiver_on    <= 1'b0;
      infrared_on    <= 1'b0;
      rsp_valid      <= 1'b0;
    end else begin
      phase          <= phase_next;
      reverse_order  <= reverse_order_next;
      next_channel   <= next_channel_next;
      channels_left  <= channels_left_next;
      stagger_reload <= stagger_reload_next;
      stagger_count  <= stagger_count_next;
      final_channel  <= final_channel_next;
      tick_count     <= tick_count_next;
      driver_on      <= driver_on_next;
      ground_on      <= ground_on_next;
      receiver_on    <= receiver_on_next;
      infrared_on    <= infrared_on_next;
      if (accept) begin
        rsp_valid                <= 1'b1;
        rsp.channel_enables      <= enabled_pad[7:0];
        rsp.transmit_enable      <= driver_on_next;
        rsp.ground_switch_closed <= ground_on_next;
        rsp.receiver_enable      <= receiver_on_next;
        rsp.infrared_out         <= infrared_on_next;
        rsp.busy_res             <= (phase_next != PH_IDLE);
        rsp.finished             <= done;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  `ASSERT_IMPL(a_driver_in_tx, clk, rst, driver_on, (phase == PH_STAGGER || phase == PH_SEND))
  `ASSERT_IMPL(a_ir_phase, clk, rst, 1'b1, (infrared_on == (phase == PH_INFRARED)))
  `ASSERT_IMPL(a_stagger_left, clk, rst, (phase == PH_STAGGER), (channels_left != '0))
  `ASSERT_NEXT(a_rsp_follows, clk, rst, accept, rsp_valid)

endmodule

### bench/phased_array_burst_sequencer_checker.sv
// Checker for the burst sequencer: predicts each status result and compares it.
`timescale 1ns / 1ps
module burst_sequencer_checker import pabs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   cmd_valid,
  input  logic                   cmd_stall,
  input  cmd_t                   cmd,
  input  logic                   rsp_valid,
  input  logic                   rsp_stall,
  input  rsp_t                   rsp,
  output int                     errors,
  output int                     pending
);

  localparam int CHANNELS = 8;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_STAGGER,
    SEQ_SEND,
    SEQ_ATTENUATE,
    SEQ_INFRARED
  } seq_phase_t;

  // Shadow configuration
  logic [6:0] burst_len;
  logic [7:0] rx_base, gnd_base, end_base, ir_len;

  // Shadow sequencer state
  seq_phase_t           seq_phase;
  logic                 reverse;
  logic [2:0]           next_ch, last_ch;
  logic [3:0]           ch_left;
  logic [STAGGER_W-1:0] stagger_reload, stagger_left;
  logic [6:0]           periods [CHANNELS];
  logic [7:0]           running;
  logic [7:0]           ticks;
  logic                 drv_on, gnd_on, rx_on, ir_on;

  rsp_t status_due [$];
  int   mismatches;

  // Enable the next channel in order and reload the stagger delay
  function automatic void enable_channel();
    running[next_ch] = 1'b1;
    // 3-bit index wraps modulo the channel count
    next_ch = reverse ? next_ch - 3'd1 : next_ch + 3'd1;
    if (ch_left != 0) ch_left--;
    stagger_left = stagger_reload;
    if (ch_left == 0) seq_phase = SEQ_SEND;
  endfunction

  // Tick count past a threshold base less half the burst length (signed)
  function automatic bit past_base(input logic [7:0] base);
    return int'(ticks) > int'(base) - int'(burst_len >> 1);
  endfunction

  // Apply one request to the shadow state and return the status it yields
  function automatic rsp_t step_sequencer(input cmd_t c);
    rsp_t s;
    int   mag;
    logic done;
    done = 1'b0;
    case (c.operation)
      OP_START_US: if (seq_phase == SEQ_IDLE) begin
        mag = c.steer_angle;
        if (mag < 0) mag = -mag;
        rx_on = 1'b0;
        drv_on = 1'b1;
        reverse = c.steer_angle[7];
        stagger_reload = '0;
        if (mag >= int'(STAGGER_MIN) && mag <= int'(STAGGER_MAX)) begin
          stagger_reload = STAGGER_TABLE[mag];
        end
        next_ch = reverse ? 3'(CHANNELS - 1) : 3'd0;
        last_ch = reverse ? 3'd0 : 3'(CHANNELS - 1);
        ch_left = 4'(CHANNELS);
        seq_phase = SEQ_STAGGER;
        enable_channel();
      end
      OP_START_IR: if (seq_phase == SEQ_IDLE) begin
        ir_on = 1'b1;
        ticks = '0;
        seq_phase = SEQ_INFRARED;
      end
      OP_CPU_CYCLE: if (seq_phase == SEQ_STAGGER) begin
        if (stagger_left != 0) stagger_left--;
        if (stagger_left == 0) enable_channel();
      end
      OP_PWM_EVENT: begin
        for (int ch = 0; ch < CHANNELS; ch++) begin
          if (c.period_mask[ch] && running[ch]) begin
            periods[ch] = periods[ch] + 7'd1;
            if (periods[ch] >= burst_len) begin
              periods[ch] = '0;
              running[ch] = 1'b0;
              // only the last channel in send phase ends transmission
              if (3'(ch) == last_ch && seq_phase == SEQ_SEND) begin
                drv_on = 1'b0;
                gnd_on = 1'b1;
                ticks = '0;
                seq_phase = SEQ_ATTENUATE;
              end
            end
          end
        end
      end
      OP_TIMER: if (seq_phase == SEQ_ATTENUATE || seq_phase == SEQ_INFRARED) begin
        if (ticks != TICK_MAX) ticks++;
        if (seq_phase == SEQ_ATTENUATE) begin
          if (past_base(rx_base)) rx_on = 1'b1;
          if (past_base(gnd_base)) gnd_on = 1'b0;
          if (past_base(end_base)) begin
            ticks = '0;
            seq_phase = SEQ_IDLE;
            done = 1'b1;
          end
        end else if (ticks > ir_len) begin
          ir_on = 1'b0;
          ticks = '0;
          seq_phase = SEQ_IDLE;
          done = 1'b1;
        end
      end
      default: ;
    endcase
    s.channel_enables      = running;
    s.transmit_enable      = drv_on;
    s.ground_switch_closed = gnd_on;
    s.receiver_enable      = rx_on;
    s.infrared_out         = ir_on;
    s.busy_res             = (seq_phase != SEQ_IDLE);
    s.finished             = done;
    return s;
  endfunction

  // Track configuration, predict on each request, compare on each result
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      burst_len = BURST_COUNT_RST;
      rx_base = RECEIVER_ON_RST;
      gnd_base = GROUND_OFF_RST;
      end_base = FINISH_RST;
      ir_len = INFRARED_LENGTH_RST;
      seq_phase = SEQ_IDLE;
      reverse = 1'b0;
      next_ch = '0;
      last_ch = '0;
      ch_left = '0;
      stagger_reload = '0;
      stagger_left = '0;
      for (int ch = 0; ch < CHANNELS; ch++) periods[ch] = '0;
      running = '0;
      ticks = '0;
      {drv_on, gnd_on, rx_on, ir_on} = '0;
      status_due.delete();
      mismatches = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (status_due.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: status result with none outstanding: en=%02h tx=%b gnd=%b rx=%b",
                     $realtime, rsp.channel_enables, rsp.transmit_enable,
                     rsp.ground_switch_closed, rsp.receiver_enable);
          end
          mismatches++;
        end else begin
          want = status_due.pop_front();
          if (rsp.channel_enables !== want.channel_enables ||
              rsp.transmit_enable !== want.transmit_enable ||
              rsp.ground_switch_closed !== want.ground_switch_closed ||
              rsp.receiver_enable !== want.receiver_enable ||
              rsp.infrared_out !== want.infrared_out ||
              rsp.busy_res !== want.busy_res ||
              rsp.finished !== want.finished) begin
            if (mismatches < 10) begin
              $display("%0t: status mismatch: expected en=%02h tx=%b gnd=%b rx=%b ir=%b %s",
                       $realtime, want.channel_enables, want.transmit_enable,
                       want.ground_switch_closed, want.receiver_enable, want.infrared_out,
                       $sformatf("busy=%b fin=%b", want.busy_res, want.finished));
              $display("%0t:   actual en=%02h tx=%b gnd=%b rx=%b ir=%b busy=%b fin=%b",
                       $realtime, rsp.channel_enables, rsp.transmit_enable,
                       rsp.ground_switch_closed, rsp.receiver_enable, rsp.infrared_out,
                       rsp.busy_res, rsp.finished);
            end
            mismatches++;
          end
        end
      end
      if (cmd_valid && !cmd_stall) status_due.push_back(step_sequencer(cmd));
      if (cfg_write) begin
        case (cfg_index)
          REG_BURST_COUNT:     burst_len = cfg_data[6:0];
          REG_RECEIVER_ON:     rx_base = cfg_data;
          REG_GROUND_OFF:      gnd_base = cfg_data;
          REG_FINISH:          end_base = cfg_data;
          REG_INFRARED_LENGTH: ir_len = cfg_data;
          default: ;
        endcase
      end
    end
    pending <= status_due.size();
    errors <= mismatches;
  end

endmodule

### bench/tb_phased_array_burst_sequencer.sv
// Testbench top for the burst sequencer: request and configuration stimulus, verdict.
`timescale 1ns / 1ps
module tb_phased_array_burst_sequencer;
  import pabs_pkg::*;

  localparam int CHANNELS = 8;
  localparam int WATCHDOG_CYCLES = 500000;
  localparam int HOLD_CYCLES = 60;
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   cmd_valid = 1'b0;
  logic                   cmd_stall;
  cmd_t                   cmd = '0;
  logic                   rsp_valid;
  logic                   rsp_stall = 1'b0;
  rsp_t                   rsp;

  int errors;
  int pending;

  int send_idle_pct = 21;
  int recv_idle_pct = 61;
  int noise_pct = 0;
  int hold_asked = 0;
  int hold_served = 0;
  int hold_left = 0;
  int sent = 0;
  int watch_cycles;

  // Configuration as last written, used to shape sequences
  int burst_now = BURST_COUNT_RST;
  int fin_now = FINISH_RST;
  int ir_now = INFRARED_LENGTH_RST;

  always #6 clk = ~clk;

  phased_array_burst_sequencer u_top (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  burst_sequencer_checker u_checker (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp),
    .errors(errors),
    .pending(pending)
  );

  // Stall results at random; serve a long hold-off when one is asked for
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_asked) begin
      hold_served <= hold_asked;
      hold_left <= HOLD_CYCLES;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Offer one request, wait for it to be taken, then maybe idle
  task automatic push_cmd(input logic [2:0] op, input logic [7:0] angle,
                          input logic [7:0] mask);
    cmd_valid <= 1'b1;
    cmd <= {op, angle, mask};
    do @(posedge clk); while (cmd_stall);
    sent++;
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Stop sending and wait until every status result has come back
  task automatic drain();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Hold one register write for a cycle; caller lowers the strobe
  task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input int val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    @(posedge clk);
  endtask

  task automatic set_config(input int bc, input int rx, input int gnd, input int fin,
                            input int ir);
    put_reg(REG_BURST_COUNT, bc);
    put_reg(REG_RECEIVER_ON, rx);
    put_reg(REG_GROUND_OFF, gnd);
    put_reg(REG_FINISH, fin);
    put_reg(REG_INFRARED_LENGTH, ir);
    cfg_write <= 1'b0;
    burst_now = bc;
    fin_now = fin;
    ir_now = ir;
  endtask

  // Mostly angles with no stagger delay, the odd -128
  function automatic int pick_angle();
    int mag;
    int roll;
    roll = $urandom_range(99);
    if (roll < 3) return -128;
    if (roll < 50) mag = $urandom_range(2, 0);
    else mag = $urandom_range(90, 31);
    return $urandom_range(1) ? -mag : mag;
  endfunction

  task automatic push_noise();
    logic [2:0] op;
    op = 3'($urandom_range(int'(OP_UNUSED_HI)));
    if (op == OP_START_US) push_cmd(op, 8'(pick_angle()), 8'($urandom_range(255)));
    else push_cmd(op, 8'($urandom_range(255)), 8'($urandom_range(255)));
  endtask

  task automatic maybe_noise();
    if ($urandom_range(99) < noise_pct) push_noise();
  endtask

  // Start, stagger all channels, run the bursts out, then tick to the end
  task automatic run_ultrasound(input int angle);
    int mag;
    int gap;
    int last;
    int hits;
    int need;
    int thr;
    logic [7:0] mask;
    push_cmd(OP_START_US, 8'(angle), 8'($urandom_range(255)));
    mag = angle < 0 ? -angle : angle;
    gap = 1;
    if (mag >= int'(STAGGER_MIN) && mag <= int'(STAGGER_MAX) && STAGGER_TABLE[mag] != 0) begin
      gap = STAGGER_TABLE[mag];
    end
    repeat ((CHANNELS - 1) * gap + $urandom_range(2)) begin
      maybe_noise();
      push_cmd(OP_CPU_CYCLE, 8'($urandom_range(255)), 8'($urandom_range(255)));
    end
    last = angle < 0 ? 0 : CHANNELS - 1;
    need = burst_now == 0 ? 1 : burst_now;
    hits = 0;
    while (hits < need) begin
      maybe_noise();
      mask = 8'($urandom_range(255));
      if ($urandom_range(99) < 70) mask[last] = 1'b1;
      if (mask[last]) hits++;
      push_cmd(OP_PWM_EVENT, 8'($urandom_range(255)), mask);
    end
    thr = fin_now - burst_now / 2;
    repeat ((thr < 0 ? 1 : thr + 1) + $urandom_range(1)) begin
      maybe_noise();
      push_cmd(OP_TIMER, 8'($urandom_range(255)), 8'($urandom_range(255)));
    end
  endtask

  task automatic run_infrared();
    push_cmd(OP_START_IR, 8'($urandom_range(255)), 8'($urandom_range(255)));
    repeat (ir_now + 1 + $urandom_range(1)) begin
      maybe_noise();
      push_cmd(OP_TIMER, 8'($urandom_range(255)), 8'($urandom_range(255)));
    end
  endtask

  // Mostly whole sequences with random content, some loose requests
  task automatic random_traffic(input int budget);
    int stop_at;
    int pick;
    stop_at = sent + budget;
    while (sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 60) run_ultrasound(pick_angle());
      else if (pick < 80) run_infrared();
      else repeat ($urandom_range(4, 1)) push_noise();
    end
  endtask

  // Watchdog
  initial begin
    for (watch_cycles = 0; watch_cycles < WATCHDOG_CYCLES; watch_cycles++) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Unused codes, requests that do nothing while idle
    for (int op = OP_UNUSED_LO; op <= OP_UNUSED_HI; op++) begin
      push_cmd(3'(op), (op == OP_UNUSED_LO) ? 8'h7f : 8'h80,
               (op == OP_UNUSED_LO) ? 8'h00 : 8'hff);
    end
    push_cmd(OP_TIMER, 8'h00, 8'hff);
    push_cmd(OP_CPU_CYCLE, 8'hff, 8'h00);
    push_cmd(OP_PWM_EVENT, 8'h00, 8'hff);
    // Infrared with starts ignored while busy
    push_cmd(OP_START_IR, 8'h00, 8'h00);
    push_cmd(OP_START_US, 8'h00, 8'h00);
    run_infrared();
    // Angle -128 gives no delay; repeat start while busy is ignored
    push_cmd(OP_START_US, 8'h80, 8'h00);
    push_cmd(OP_START_IR, 8'h00, 8'h00);
    run_ultrasound(-128);
    // Receiver stays on after the finish
    push_cmd(OP_TIMER, 8'h00, 8'h00);

    // Short bursts, a threshold below zero, the smallest stagger delay
    drain();
    set_config(3, 0, 8, 10, 6);
    run_ultrasound(3);
    run_ultrasound(-31);
    run_ultrasound(2);

    noise_pct = 8;
    random_traffic(40);

    // Zero burst count, ground still closed at the finish; long result hold-off
    drain();
    send_idle_pct = 61;
    recv_idle_pct = 21;
    set_config(0, 4, 9, 6, 3);
    hold_asked++;
    random_traffic(30);

    // No idling; pause until everything is back halfway through
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config(6, 20, 0, 12, 7);
    random_traffic(15);
    drain();
    random_traffic(15);

    drain();
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
